### sv/clnb_pkg.sv
// ----------------------------------------------------------------------------
// clnb_pkg
// Types, codes and constants shared by the character LCD nibble interface.
// ----------------------------------------------------------------------------
package clnb_pkg;

    // Request codes carried in the cmd field.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_BYTE  = 3'd1;
    localparam logic [2:0] CMD_CHAR  = 3'd2;
    localparam logic [2:0] CMD_GOTO  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;
    localparam logic [2:0] CMD_INIT  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_TICKS_PER_US  = 3'd0;
    localparam logic [2:0] REG_CMD_WAIT_US   = 3'd1;
    localparam logic [2:0] REG_CLEAR_WAIT_US = 3'd2;
    localparam logic [2:0] REG_CHAR_PHASE_US = 3'd3;
    localparam logic [2:0] REG_POWER_WAIT_US = 3'd4;
    localparam logic [2:0] REG_PULSE_US      = 3'd5;

    localparam int CFG_DATA_W = 18;
    localparam int US_W       = 18;
    localparam int WAIT_W     = 26;

    localparam logic [US_W-1:0] INIT_FIRST_EXTRA_US = 18'd5000;
    localparam logic [US_W-1:0] INIT_EXTRA_US       = 18'd105;
    localparam logic [US_W-1:0] CLEAR_EXTRA_US      = 18'd2000;

    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [7:0] CLEAR_BYTE  = 8'h01;

    localparam logic [3:0] INIT_LEN  = 4'd8;
    localparam logic [3:0] CLEAR_LEN = 4'd2;
    localparam logic [3:0] SINGLE_LEN = 4'd1;
    localparam logic [3:0] INIT_LAST_EXTRA_STEP = 4'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETUP   = 3'd1,
        PH_HI_EN   = 3'd2,
        PH_HI_FALL = 3'd3,
        PH_LO_EN   = 3'd4,
        PH_LO_FALL = 3'd5,
        PH_EXTRA   = 3'd6,
        PH_POWER   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_INIT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
    } t_in;

    typedef struct packed {
        logic [3:0] lcd_nibble;
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic       busy_res;
        logic       rejected;
    } t_out;

    typedef struct packed {
        logic [7:0]  ticks_per_us;
        logic [9:0]  cmd_wait_us;
        logic [13:0] clear_wait_us;
        logic [13:0] char_phase_us;
        logic [17:0] power_wait_us;
        logic [6:0]  pulse_us;
    } t_cfg;

    // Power-on command bytes of the init sequence.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h30;
            3'd1:    b = 8'h30;
            3'd2:    b = 8'h30;
            3'd3:    b = 8'h20;
            3'd4:    b = 8'h28;
            3'd5:    b = 8'h06;
            3'd6:    b = 8'h01;
            3'd7:    b = 8'h0F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### sv/char_lcd_nibble_interface.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// Character LCD controller driving a 4-bit write-only display bus.
// ----------------------------------------------------------------------------
// Every accepted item, request or tick, yields exactly one pin result. An
// item is taken into an input register, the sequencer advances its state by
// one clock of display time and forms the pin levels in the same cycle, and
// the result lands in an output register. One item
// is accepted every cycle while the output side keeps up. The path between
// the two registers holds the next-phase selection and one 18 x 8 multiply
// that turns a microsecond figure into the tick count of the new phase.
// Requests that arrive while a sequence runs are reported as rejected.
module char_lcd_nibble_interface
    import clnb_pkg::*;
#(
    parameter int COLUMNS = 40
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    logic w_fire;
    t_cfg w_cfg;
    t_out w_res;

    assign o_cfg_ready = 1'b1;
    assign w_fire      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_fire;

    clnb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    clnb_seq #(
        .COLUMNS (COLUMNS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A result only appears after an item sat in the input register.
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("char_lcd_nibble_interface: result without an input item");

    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_fire)
        else $error("char_lcd_nibble_interface: result overwritten while stalled");

    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.enable) |-> o_out_data.busy_res)
        else $error("char_lcd_nibble_interface: enable strobe outside a sequence");

endmodule

### sv/clnb_cfg.sv
// ----------------------------------------------------------------------------
// clnb_cfg
// Timing configuration registers, written through the configuration port.
// ----------------------------------------------------------------------------
module clnb_cfg
    import clnb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [2:0]            i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_us  <= 8'd16;
            r_cfg.cmd_wait_us   <= 10'd40;
            r_cfg.clear_wait_us <= 14'd2000;
            r_cfg.char_phase_us <= 14'd1000;
            r_cfg.power_wait_us <= 18'd120000;
            r_cfg.pulse_us      <= 7'd1;
        end else if (i_we) begin
            case (i_index)
                REG_TICKS_PER_US:  r_cfg.ticks_per_us  <= i_data[7:0];
                REG_CMD_WAIT_US:   r_cfg.cmd_wait_us   <= i_data[9:0];
                REG_CLEAR_WAIT_US: r_cfg.clear_wait_us <= i_data[13:0];
                REG_CHAR_PHASE_US: r_cfg.char_phase_us <= i_data[13:0];
                REG_POWER_WAIT_US: r_cfg.power_wait_us <= i_data[17:0];
                REG_PULSE_US:      r_cfg.pulse_us      <= i_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/clnb_seq.sv
// ----------------------------------------------------------------------------
// clnb_seq
// Pin sequencer: phase, wait counter and byte sequence state, advanced once
// per processed item, with the pin result formed from the new state.
// ----------------------------------------------------------------------------
module clnb_seq
    import clnb_pkg::*;
#(
    parameter int COLUMNS = 40
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_res
);

    t_phase            r_phase, n_phase;
    t_kind             r_kind,  n_kind;
    logic [WAIT_W-1:0] r_wait,  n_wait;
    logic [7:0]        r_byte,  n_byte;
    logic              r_rs,    n_rs;
    logic [3:0]        r_step,  n_step;

    logic              w_request;
    logic              w_rejected;
    logic              w_load;
    logic              w_start;
    logic [3:0]        w_step1;
    logic [3:0]        w_len;
    logic              w_extra;
    logic [5:0]        w_col;
    logic [US_W-1:0]   w_us;
    logic [WAIT_W-1:0] w_ticks;
    logic              w_drive;

    assign w_request = (i_item.cmd == CMD_BYTE) || (i_item.cmd == CMD_CHAR) ||
                       (i_item.cmd == CMD_GOTO) || (i_item.cmd == CMD_CLEAR) ||
                       (i_item.cmd == CMD_INIT);
    assign w_step1   = r_step + 4'd1;
    assign w_col     = (i_item.col > 6'(COLUMNS - 1)) ? 6'(COLUMNS - 1) : i_item.col;

    always_comb begin
        case (r_kind)
            KIND_INIT:  w_len = INIT_LEN;
            KIND_CLEAR: w_len = CLEAR_LEN;
            default:    w_len = SINGLE_LEN;
        endcase
        case (r_kind)
            KIND_CLEAR: w_extra = (r_step == 4'd0);
            KIND_INIT:  w_extra = (r_step <= INIT_LAST_EXTRA_STEP);
            default:    w_extra = 1'b0;
        endcase
    end

    // Next state. w_start begins the byte at step n_step of the current sequence.
    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_wait     = r_wait;
        n_byte     = r_byte;
        n_rs       = r_rs;
        n_step     = r_step;
        w_load     = 1'b0;
        w_start    = 1'b0;
        w_rejected = 1'b0;
        if (r_phase != PH_IDLE) begin
            w_rejected = w_request;
            if (r_wait != '0) begin
                n_wait = r_wait - WAIT_W'(1);
            end else begin
                case (r_phase)
                    PH_SETUP: begin
                        n_phase = PH_HI_EN;
                        w_load  = 1'b1;
                    end
                    PH_HI_EN: begin
                        n_phase = PH_HI_FALL;
                        w_load  = 1'b1;
                    end
                    PH_HI_FALL: begin
                        n_phase = PH_LO_EN;
                        w_load  = 1'b1;
                    end
                    PH_LO_EN: begin
                        n_phase = PH_LO_FALL;
                        w_load  = 1'b1;
                    end
                    PH_LO_FALL, PH_EXTRA: begin
                        if (r_phase == PH_LO_FALL && w_extra) begin
                            n_phase = PH_EXTRA;
                            w_load  = 1'b1;
                        end else if (w_step1 < w_len) begin
                            n_step  = w_step1;
                            w_start = 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                            n_wait  = '0;
                            n_step  = 4'd0;
                            n_kind  = KIND_NONE;
                        end
                    end
                    PH_POWER: begin
                        n_step  = 4'd0;
                        w_start = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else if (w_request) begin
            n_step = 4'd0;
            case (i_item.cmd)
                CMD_BYTE, CMD_CHAR: begin
                    n_kind  = KIND_SINGLE;
                    n_byte  = i_item.value;
                    n_rs    = (i_item.cmd == CMD_CHAR);
                    n_phase = PH_SETUP;
                    w_load  = 1'b1;
                end
                CMD_GOTO: begin
                    n_kind  = KIND_SINGLE;
                    n_byte  = CURSOR_BASE | ({1'b0, i_item.row, 6'd0} + {2'b00, w_col});
                    n_rs    = 1'b0;
                    n_phase = PH_SETUP;
                    w_load  = 1'b1;
                end
                CMD_CLEAR: begin
                    n_kind  = KIND_CLEAR;
                    w_start = 1'b1;
                end
                default: begin
                    n_kind  = KIND_INIT;
                    n_rs    = 1'b0;
                    n_phase = PH_POWER;
                    w_load  = 1'b1;
                end
            endcase
        end
        if (w_start) begin
            if (n_kind == KIND_INIT) begin
                n_byte = init_byte(n_step[2:0]);
                n_rs   = 1'b0;
            end else if (n_kind == KIND_CLEAR) begin
                n_byte = (n_step == 4'd0) ? CLEAR_BYTE : CURSOR_BASE;
                n_rs   = 1'b0;
            end
            n_phase = PH_SETUP;
            w_load  = 1'b1;
        end
        if (w_load) begin
            n_wait = (w_ticks == '0) ? '0 : w_ticks - WAIT_W'(1);
        end
    end

    // Length in microseconds of the phase being entered.
    always_comb begin
        if (n_phase == PH_POWER) begin
            w_us = i_cfg.power_wait_us;
        end else if (n_phase == PH_EXTRA) begin
            if (n_kind == KIND_CLEAR) begin
                w_us = CLEAR_EXTRA_US;
            end else begin
                w_us = (n_step == 4'd0) ? INIT_FIRST_EXTRA_US : INIT_EXTRA_US;
            end
        end else if (n_rs) begin
            w_us = US_W'(i_cfg.char_phase_us);
        end else if (n_phase == PH_LO_FALL) begin
            w_us = (n_byte < 8'd4) ? US_W'(i_cfg.clear_wait_us) : US_W'(i_cfg.cmd_wait_us);
        end else begin
            w_us = US_W'(i_cfg.pulse_us);
        end
    end

    assign w_ticks = {8'd0, w_us} * {18'd0, i_cfg.ticks_per_us};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= KIND_NONE;
            r_wait  <= '0;
            r_byte  <= 8'd0;
            r_rs    <= 1'b0;
            r_step  <= 4'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_wait  <= n_wait;
            r_byte  <= n_byte;
            r_rs    <= n_rs;
            r_step  <= n_step;
        end
    end

    assign w_drive = (n_phase >= PH_SETUP) && (n_phase <= PH_LO_FALL);

    always_comb begin
        o_res            = '0;
        o_res.rejected   = w_rejected;
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.read_write = 1'b0;
        if (w_drive) begin
            o_res.lcd_nibble = (n_phase <= PH_HI_FALL) ? n_byte[7:4] : n_byte[3:0];
            o_res.reg_select = n_rs;
            o_res.enable     = (n_phase == PH_HI_EN) || (n_phase == PH_LO_EN);
        end
    end

    // The idle state carries no pending wait and no open sequence.
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_wait == '0))
        else $error("clnb_seq: wait count left over in idle");

    a_idle_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_kind == KIND_NONE))
        else $error("clnb_seq: sequence kind disagrees with idle phase");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < INIT_LEN)
        else $error("clnb_seq: sequence step past the last byte");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.rejected) |-> (r_phase != PH_IDLE))
        else $error("clnb_seq: request rejected while idle");

endmodule

### sim/char_lcd_nibble_interface_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_tb
// Self-checking bench for the 4-bit character LCD controller. A short scripted
// run covers idle ticks, every request type, column saturation and refused
// requests. Random requests and ticks then run under several timing settings,
// from one-cycle phases to full-width waits. A cycle model of the sequencer
// predicts the pin levels of every accepted item. The predictions are queued
// and compared in order with the results that the block delivers.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clnb_pkg::*;

    localparam int LCD_COLS      = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_OUT_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [7:0] GOTO_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'h40;
    localparam logic [7:0] CLEAR_CODE = 8'h01;

    localparam int unsigned CLEAR_HOLD_US         = 2000;
    localparam int unsigned POWERON_FIRST_HOLD_US = 5000;
    localparam int unsigned POWERON_HOLD_US       = 105;

    localparam logic [0:7][7:0] POWERON_BYTES = {
        8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h06, 8'h01, 8'h0F
    };

    // Timing settings: ticks/us, cmd wait, clear wait, char phase, power wait, pulse.
    localparam t_cfg CFG_RESET = '{8'd16, 10'd40, 14'd2000, 14'd1000, 18'd120000, 7'd1};
    localparam t_cfg CFG_STEP  = '{8'd1, 10'd2, 14'd100, 14'd3, 18'd1000, 7'd1};
    localparam t_cfg CFG_ZERO  = '{8'd0, 10'd0, 14'd0, 14'd0, 18'd0, 7'd0};
    localparam t_cfg CFG_MID   = '{8'd2, 10'd5, 14'd100, 14'd2, 18'd1000, 7'd3};
    localparam t_cfg CFG_LOW   = '{8'd1, 10'd1, 14'd100, 14'd1, 18'd1000, 7'd1};
    localparam t_cfg CFG_WIDE  = '{8'd0, 10'd1000, 14'd10000, 14'd10000, 18'd200000, 7'd100};
    localparam t_cfg CFG_HIGH  = '{8'd255, 10'd1023, 14'd16383, 14'd16383, 18'd262143, 7'd127};

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
        bit   run_out;
    } t_step_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [2:0]            i_cfg_index = REG_TICKS_PER_US;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  o_cfg_ready;

    // Sequencer model state.
    t_cfg        regs_now;
    t_phase      ph;
    int unsigned hold;
    logic [7:0]  byte_now;
    logic        rs_now;
    logic [3:0]  step_no;
    t_kind       kind_now;

    t_out        pending_pins[$];
    t_out        want_pins;
    t_step_row   script[20];

    int send_idle_pct;
    int recv_stall_pct;
    int failures;
    int transfers;
    int results_checked;
    int refused;

    char_lcd_nibble_interface #(
        .COLUMNS(LCD_COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned phase_us(input t_phase p);
        if (p == PH_POWER) return regs_now.power_wait_us;
        if (p == PH_EXTRA) begin
            if (kind_now == KIND_CLEAR) return CLEAR_HOLD_US;
            return (step_no == 4'd0) ? POWERON_FIRST_HOLD_US : POWERON_HOLD_US;
        end
        if (rs_now) return regs_now.char_phase_us;
        if (p == PH_LO_FALL) begin
            return (byte_now < 8'd4) ? regs_now.clear_wait_us : regs_now.cmd_wait_us;
        end
        return regs_now.pulse_us;
    endfunction

    // A phase loads its hold count with its tick count less one, and zero for a zero count.
    function automatic void enter_phase(input t_phase p);
        int unsigned ticks;
        ph    = p;
        ticks = (phase_us(p) * regs_now.ticks_per_us) & 32'h03FF_FFFF;
        hold  = (ticks != 0) ? ticks - 1 : 0;
    endfunction

    function automatic void load_byte();
        if (kind_now == KIND_INIT) begin
            byte_now = POWERON_BYTES[step_no[2:0]];
            rs_now   = 1'b0;
        end else if (kind_now == KIND_CLEAR) begin
            byte_now = (step_no == 4'd0) ? CLEAR_CODE : GOTO_BASE;
            rs_now   = 1'b0;
        end
        enter_phase(PH_SETUP);
    endfunction

    function automatic void next_byte();
        int unsigned len;
        step_no = step_no + 4'd1;
        len = (kind_now == KIND_INIT) ? 8 : (kind_now == KIND_CLEAR) ? 2 : 1;
        if (step_no < len) begin
            load_byte();
        end else begin
            ph       = PH_IDLE;
            hold     = 0;
            step_no  = 4'd0;
            kind_now = KIND_NONE;
        end
    endfunction

    function automatic bit extra_hold();
        if (kind_now == KIND_CLEAR) return step_no == 4'd0;
        if (kind_now == KIND_INIT) return step_no <= 4'd3;
        return 1'b0;
    endfunction

    function automatic void tick_sequencer();
        if (hold > 0) begin
            hold = hold - 1;
            return;
        end
        case (ph)
            PH_SETUP, PH_HI_EN, PH_HI_FALL, PH_LO_EN: begin
                enter_phase(t_phase'(ph + 3'd1));
            end
            PH_LO_FALL: begin
                if (extra_hold()) enter_phase(PH_EXTRA);
                else next_byte();
            end
            PH_EXTRA: begin
                next_byte();
            end
            PH_POWER: begin
                step_no = 4'd0;
                load_byte();
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase
    endfunction

    // Pin levels for one accepted item; busy is judged before the item acts.
    function automatic t_out predict_pins(input t_in it);
        t_out       pins;
        bit         is_req;
        logic [5:0] col;
        pins   = '0;
        is_req = (it.cmd >= CMD_BYTE) && (it.cmd <= CMD_INIT);
        if (ph != PH_IDLE) begin
            pins.rejected = is_req;
            tick_sequencer();
        end else if (is_req) begin
            step_no = 4'd0;
            case (it.cmd)
                CMD_CLEAR: begin
                    kind_now = KIND_CLEAR;
                    load_byte();
                end
                CMD_INIT: begin
                    kind_now = KIND_INIT;
                    rs_now   = 1'b0;
                    enter_phase(PH_POWER);
                end
                default: begin
                    kind_now = KIND_SINGLE;
                    if (it.cmd == CMD_GOTO) begin
                        col      = (it.col > LCD_COLS - 1) ? 6'(LCD_COLS - 1) : it.col;
                        byte_now = GOTO_BASE | ((it.row ? ROW1_BASE : 8'h00) + {2'b00, col});
                        rs_now   = 1'b0;
                    end else begin
                        byte_now = it.value;
                        rs_now   = (it.cmd == CMD_CHAR);
                    end
                    enter_phase(PH_SETUP);
                end
            endcase
        end
        if (ph >= PH_SETUP && ph <= PH_LO_FALL) begin
            pins.lcd_nibble = (ph <= PH_HI_FALL) ? byte_now[7:4] : byte_now[3:0];
            pins.reg_select = rs_now;
            pins.enable     = (ph == PH_HI_EN) || (ph == PH_LO_EN);
        end
        pins.busy_res = (ph != PH_IDLE);
        return pins;
    endfunction

    function automatic t_in tick_item();
        t_in it;
        it.cmd   = CMD_TICK;
        it.value = 8'($urandom_range(255));
        it.row   = 1'($urandom_range(1));
        it.col   = 6'($urandom_range(63));
        return it;
    endfunction

    // Mostly a request while idle followed by ticks, with some refused requests
    // thrown in while a sequence runs and undefined codes in either state.
    function automatic t_in random_item();
        t_in it;
        int  pick;
        it   = tick_item();
        pick = $urandom_range(99);
        if (ph == PH_IDLE) begin
            if (pick < 60) it.cmd = 3'($urandom_range(CMD_INIT, CMD_BYTE));
            else if (pick < 65) it.cmd = 3'($urandom_range(7, 6));
        end else begin
            if (pick < 6) it.cmd = 3'($urandom_range(CMD_INIT, CMD_BYTE));
            else if (pick < 9) it.cmd = 3'($urandom_range(7, 6));
        end
        return it;
    endfunction

    function automatic t_step_row mk_row(input logic [2:0] cmd, input logic [7:0] value,
                                         input logic row, input logic [5:0] col,
                                         input bit typed, input t_out want, input bit run_out);
        t_step_row r;
        r.item    = '{cmd, value, row, col};
        r.typed   = typed;
        r.want    = want;
        r.run_out = run_out;
        return r;
    endfunction

    task automatic transfer(input t_in it, input bit typed, input t_out want);
        t_out got;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = predict_pins(it);
        if (got.rejected) refused++;
        pending_pins.push_back(typed ? want : got);
        transfers++;
    endtask

    task automatic run_to_idle();
        int guard;
        guard = 0;
        while (ph != PH_IDLE && guard < RUN_OUT_LIMIT) begin
            transfer(tick_item(), 1'b0, '0);
            guard++;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TICKS_PER_US:  regs_now.ticks_per_us  = data[7:0];
            REG_CMD_WAIT_US:   regs_now.cmd_wait_us   = data[9:0];
            REG_CLEAR_WAIT_US: regs_now.clear_wait_us = data[13:0];
            REG_CHAR_PHASE_US: regs_now.char_phase_us = data[13:0];
            REG_POWER_WAIT_US: regs_now.power_wait_us = data[17:0];
            REG_PULSE_US:      regs_now.pulse_us      = data[6:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(REG_TICKS_PER_US, 32'(c.ticks_per_us));
        write_reg(REG_CMD_WAIT_US, 32'(c.cmd_wait_us));
        write_reg(REG_CLEAR_WAIT_US, 32'(c.clear_wait_us));
        write_reg(REG_CHAR_PHASE_US, 32'(c.char_phase_us));
        write_reg(REG_POWER_WAIT_US, 32'(c.power_wait_us));
        write_reg(REG_PULSE_US, 32'(c.pulse_us));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_script(input int first, input int last);
        for (int i = first; i <= last; i++) begin
            transfer(script[i].item, script[i].typed, script[i].want);
            if (script[i].run_out) run_to_idle();
        end
    endtask

    // Halfway through, the sender holds off until every result is back.
    task automatic run_phase(input t_cfg c, input int count, input bit run_out);
        settle();
        program_regs(c);
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) settle();
            transfer(random_item(), 1'b0, '0);
        end
        if (run_out) run_to_idle();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pins.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: unexpected pin result %h", $time, o_out_data);
                end
            end else begin
                want_pins = pending_pins.pop_front();
                results_checked++;
                if (o_out_data.lcd_nibble !== want_pins.lcd_nibble ||
                    o_out_data.reg_select !== want_pins.reg_select ||
                    o_out_data.read_write !== want_pins.read_write ||
                    o_out_data.enable     !== want_pins.enable     ||
                    o_out_data.busy_res   !== want_pins.busy_res   ||
                    o_out_data.rejected   !== want_pins.rejected) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("%0t: expected nib=%h rs=%b rw=%b en=%b busy=%b rej=%b",
                                 $time, want_pins.lcd_nibble, want_pins.reg_select,
                                 want_pins.read_write, want_pins.enable,
                                 want_pins.busy_res, want_pins.rejected);
                        $display("%0t:   actual nib=%h rs=%b rw=%b en=%b busy=%b rej=%b",
                                 $time, o_out_data.lcd_nibble, o_out_data.reg_select,
                                 o_out_data.read_write, o_out_data.enable,
                                 o_out_data.busy_res, o_out_data.rejected);
                    end
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        regs_now        = CFG_RESET;
        ph              = PH_IDLE;
        hold            = 0;
        byte_now        = 8'h00;
        rs_now          = 1'b0;
        step_no         = 4'd0;
        kind_now        = KIND_NONE;
        failures        = 0;
        transfers       = 0;
        results_checked = 0;
        refused         = 0;
        send_idle_pct   = 38;
        recv_stall_pct  = 76;

        // Under reset timing: idle ticks, undefined codes, a saturated go to
        // position and a request refused while it runs.
        script[0]  = mk_row(CMD_TICK, 8'h00, 1'b0, 6'd0, 1'b1, '0, 1'b0);
        script[1]  = mk_row(3'd7, 8'hFF, 1'b1, 6'd63, 1'b1, '0, 1'b0);
        script[2]  = mk_row(3'd6, 8'hA5, 1'b0, 6'd21, 1'b1, '0, 1'b0);
        script[3]  = mk_row(CMD_GOTO, 8'h5A, 1'b1, 6'd63, 1'b1,
                            '{4'hE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0);
        script[4]  = mk_row(CMD_CHAR, 8'h41, 1'b0, 6'd0, 1'b1,
                            '{4'hE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1);
        // Under short timing: command codes on both sides of the long wait,
        // characters, positions, clear and init with refused requests.
        script[5]  = mk_row(CMD_BYTE, 8'h00, 1'b0, 6'd0, 1'b1,
                            '{4'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1);
        script[6]  = mk_row(CMD_BYTE, 8'h03, 1'b0, 6'd0, 1'b0, '0, 1'b1);
        script[7]  = mk_row(CMD_BYTE, 8'h04, 1'b1, 6'd63, 1'b0, '0, 1'b1);
        script[8]  = mk_row(CMD_BYTE, 8'hFF, 1'b0, 6'd0, 1'b0, '0, 1'b1);
        script[9]  = mk_row(CMD_CHAR, 8'h00, 1'b0, 6'd0, 1'b0, '0, 1'b1);
        script[10] = mk_row(CMD_CHAR, 8'hFF, 1'b1, 6'd63, 1'b0, '0, 1'b1);
        script[11] = mk_row(CMD_GOTO, 8'h00, 1'b0, 6'd0, 1'b0, '0, 1'b1);
        script[12] = mk_row(CMD_GOTO, 8'hFF, 1'b1, 6'd39, 1'b0, '0, 1'b1);
        script[13] = mk_row(CMD_GOTO, 8'h00, 1'b0, 6'd40, 1'b0, '0, 1'b1);
        script[14] = mk_row(CMD_CLEAR, 8'h00, 1'b0, 6'd0, 1'b0, '0, 1'b0);
        script[15] = mk_row(CMD_BYTE, 8'h55, 1'b0, 6'd0, 1'b0, '0, 1'b1);
        script[16] = mk_row(CMD_INIT, 8'hAA, 1'b1, 6'd42, 1'b1,
                            '{4'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0);
        script[17] = mk_row(CMD_CLEAR, 8'h00, 1'b0, 6'd0, 1'b0, '0, 1'b0);
        script[18] = mk_row(3'd6, 8'h00, 1'b0, 6'd0, 1'b0, '0, 1'b1);
        script[19] = mk_row(CMD_TICK, 8'h3C, 1'b1, 6'd17, 1'b1, '0, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_script(0, 4);
        settle();
        program_regs(CFG_STEP);
        run_script(5, 19);

        run_phase(CFG_ZERO, 350, 1'b1);
        run_phase(CFG_MID, 150, 1'b1);

        send_idle_pct  = 76;
        recv_stall_pct = 38;
        run_phase(CFG_LOW, 200, 1'b1);
        run_phase(CFG_WIDE, 250, 1'b1);

        // The last two settings leave long waits behind, so they come last.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_phase(CFG_ZERO, 250, 1'b1);
        run_phase(CFG_RESET, 80, 1'b0);
        run_phase(CFG_HIGH, 80, 1'b0);

        i_in_valid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d pin results from %0d transfers, %0d of them refused requests.",
                 results_checked, transfers, refused);
        $display("Timing ran from one-cycle phases to full-width waits, with sender and sink gaps.");
        if (failures == 0 && pending_pins.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/clnb_pkg.sv
sv/clnb_cfg.sv
sv/clnb_seq.sv
sv/char_lcd_nibble_interface.sv
sim/char_lcd_nibble_interface_tb.sv
